// ===== hw/rtl/kq_pkg.sv =====
// Shared types, constants and helpers for the key event queue.
// No dependencies; every other file of the block but kq_ram uses this package.
package kq_pkg;

	localparam int QUEUE_DEPTH = 16;
	localparam int PTR_W       = $clog2(QUEUE_DEPTH);
	localparam int KEY_W       = 8;
	localparam int NUM_KEYS    = 1 << KEY_W;
	localparam int KIND_W      = 2;
	localparam int EV_W        = KIND_W + KEY_W + 1;

	typedef enum logic [1:0] {
		MODE_KEY   = 2'd0,
		MODE_FOCUS = 2'd1,
		MODE_POP   = 2'd2
	} mode_t;

	typedef enum logic [KIND_W-1:0] {
		KIND_KEY         = 2'd0,
		KIND_RELEASE_ALL = 2'd1,
		KIND_RESYNC      = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		ST_QUEUED   = 3'd0,
		ST_IGNORED  = 3'd1,
		ST_DROPPED  = 3'd2,
		ST_OVERFLOW = 3'd3,
		ST_EMPTY    = 3'd4,
		ST_POPPED   = 3'd5
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_LOAD,
		S_EXEC,
		S_OUT
	} state_t;

	typedef struct packed {
		logic capture;
		logic exec;
	} cmd_t;

	typedef struct packed {
		logic again;
	} sts_t;

	typedef struct packed {
		status_t           status;
		logic              resync_queued;
		kind_t             kind;
		logic [KEY_W-1:0]  key;
		logic              down;
	} res_t;

	function automatic logic [PTR_W-1:0] ptr_adv(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

endpackage

// ===== hw/rtl/kq_if.sv =====
// Request and response channel interfaces (valid/ready) of the key event queue.
// Depends on kq_pkg for field widths.
interface kq_req_if;
	logic                     valid;
	logic                     ready;
	logic [1:0]               mode;
	logic [kq_pkg::KEY_W-1:0] key_id;
	logic                     key_down;

	modport source (output valid, output mode, output key_id, output key_down, input ready);
	modport sink   (input valid, input mode, input key_id, input key_down, output ready);
endinterface

interface kq_rsp_if;
	logic                     valid;
	logic                     ready;
	logic [2:0]               status;
	logic                     resync_queued;
	logic [1:0]               event_kind;
	logic [kq_pkg::KEY_W-1:0] event_key;
	logic                     event_down;

	modport source (output valid, output status, output resync_queued, output event_kind,
		output event_key, output event_down, input ready);
	modport sink   (input valid, input status, input resync_queued, input event_kind,
		input event_key, input event_down, output ready);
endinterface

// ===== hw/rtl/kq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module kq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== hw/rtl/kq_ctrl.sv =====
// Sequencing state machine of the key event queue.
// Depends on kq_pkg; drives the datapath through cmd_t, reads sts_t.
module kq_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output kq_pkg::cmd_t  cmd,
	input  kq_pkg::sts_t  sts
);
	import kq_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		req_ready   = 1'b0;
		rsp_valid   = 1'b0;
		cmd.capture = 1'b0;
		cmd.exec    = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.capture = 1'b1;
					state_d     = S_LOAD;
				end
			end
			S_LOAD: begin
				state_d = S_EXEC;
			end
			S_EXEC: begin
				cmd.exec = 1'b1;
				if (!sts.again) begin
					state_d = S_OUT;
				end
			end
			S_OUT: begin
				rsp_valid = 1'b1;
				if (rsp_ready) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

// ===== hw/rtl/kq_dp.sv =====
// Datapath: item registers, queue pointers, event RAM, key state RAM and valid bits.
// Depends on kq_pkg and kq_ram.
module kq_dp (
	input  logic                     clk,
	input  logic                     arst_n,
	input  kq_pkg::cmd_t             cmd,
	output kq_pkg::sts_t             sts,
	input  logic [1:0]               in_mode,
	input  logic [kq_pkg::KEY_W-1:0] in_key,
	input  logic                     in_down,
	output kq_pkg::res_t             res
);
	import kq_pkg::*;

	logic [1:0]          mode_q;
	logic [KEY_W-1:0]    key_q;
	logic                down_q;
	logic                rq_q;
	logic                pend_q;
	logic [PTR_W-1:0]    wptr_q;
	logic [PTR_W-1:0]    rptr_q;
	logic [NUM_KEYS-1:0] kvalid_q;
	res_t                res_q;

	logic [EV_W-1:0]     ev_rd;
	logic [0:0]          pm_rd;

	logic                full;
	logic                pressed;
	logic                ev_we;
	logic [EV_W-1:0]     ev_wd;
	logic                pm_we;
	logic                wptr_inc;
	logic                rptr_inc;
	logic                clear_all;
	logic                set_pend;
	logic                flush_ok;
	logic                done;
	res_t                res_d;

	kq_ram #(.WIDTH(EV_W), .DEPTH(QUEUE_DEPTH)) u_ev_ram (
		.clk   (clk),
		.we    (ev_we),
		.waddr (wptr_q),
		.wdata (ev_wd),
		.re    (cmd.capture),
		.raddr (rptr_q),
		.rdata (ev_rd)
	);

	kq_ram #(.WIDTH(1), .DEPTH(NUM_KEYS)) u_pm_ram (
		.clk   (clk),
		.we    (pm_we),
		.waddr (key_q),
		.wdata (down_q),
		.re    (cmd.capture),
		.raddr (in_key),
		.rdata (pm_rd)
	);

	assign full    = (ptr_adv(wptr_q) == rptr_q);
	assign pressed = kvalid_q[key_q] & pm_rd[0];

	always_comb begin
		ev_we     = 1'b0;
		ev_wd     = '0;
		pm_we     = 1'b0;
		wptr_inc  = 1'b0;
		rptr_inc  = 1'b0;
		clear_all = 1'b0;
		set_pend  = 1'b0;
		flush_ok  = 1'b0;
		done      = 1'b1;
		res_d.status        = ST_IGNORED;
		res_d.resync_queued = rq_q;
		res_d.kind          = KIND_KEY;
		res_d.key           = '0;
		res_d.down          = 1'b0;
		if (cmd.exec) begin
			priority if ((mode_q == MODE_KEY || mode_q == MODE_FOCUS) && pend_q) begin
				if (full) begin
					res_d.status = ST_DROPPED;
				end else begin
					ev_we     = 1'b1;
					ev_wd     = {KIND_RESYNC, {KEY_W{1'b0}}, 1'b0};
					wptr_inc  = 1'b1;
					clear_all = 1'b1;
					flush_ok  = 1'b1;
					done      = 1'b0;
				end
			end else if (mode_q == MODE_KEY) begin
				if (key_q == '0 || pressed == down_q) begin
					res_d.status = ST_IGNORED;
				end else if (full) begin
					set_pend     = 1'b1;
					res_d.status = ST_OVERFLOW;
				end else begin
					ev_we        = 1'b1;
					ev_wd        = {KIND_KEY, key_q, down_q};
					wptr_inc     = 1'b1;
					pm_we        = 1'b1;
					res_d.status = ST_QUEUED;
				end
			end else if (mode_q == MODE_FOCUS) begin
				if (full) begin
					set_pend     = 1'b1;
					res_d.status = ST_OVERFLOW;
				end else begin
					ev_we        = 1'b1;
					ev_wd        = {KIND_RELEASE_ALL, {KEY_W{1'b0}}, 1'b0};
					wptr_inc     = 1'b1;
					clear_all    = 1'b1;
					res_d.status = ST_QUEUED;
				end
			end else if (mode_q == MODE_POP) begin
				if (rptr_q == wptr_q) begin
					res_d.status = ST_EMPTY;
				end else begin
					rptr_inc     = 1'b1;
					res_d.status = ST_POPPED;
					res_d.kind   = kind_t'(ev_rd[EV_W-1 -: KIND_W]);
					res_d.key    = ev_rd[KEY_W:1];
					res_d.down   = ev_rd[0];
				end
			end else begin
				res_d.status = ST_IGNORED;
			end
		end
	end

	assign sts.again = cmd.exec & ~done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q   <= '0;
			rptr_q   <= '0;
			pend_q   <= 1'b0;
			rq_q     <= 1'b0;
			kvalid_q <= '0;
		end else begin
			if (wptr_inc) begin
				wptr_q <= ptr_adv(wptr_q);
			end
			if (rptr_inc) begin
				rptr_q <= ptr_adv(rptr_q);
			end
			if (set_pend) begin
				pend_q <= 1'b1;
			end else if (flush_ok) begin
				pend_q <= 1'b0;
			end
			if (cmd.capture) begin
				rq_q <= 1'b0;
			end else if (flush_ok) begin
				rq_q <= 1'b1;
			end
			if (clear_all) begin
				kvalid_q <= '0;
			end else if (pm_we) begin
				kvalid_q[key_q] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			mode_q <= in_mode;
			key_q  <= in_key;
			down_q <= in_down;
		end
		if (cmd.exec && done) begin
			res_q <= res_d;
		end
	end

	assign res = res_q;

	a_wptr_range: assert property (@(posedge clk) disable iff (!arst_n)
		wptr_q <= PTR_W'(QUEUE_DEPTH - 1) && rptr_q <= PTR_W'(QUEUE_DEPTH - 1))
		else $error("queue pointer out of range");

	a_flush_clears_pend: assert property (@(posedge clk) disable iff (!arst_n)
		sts.again |=> !pend_q && rq_q && kvalid_q == '0)
		else $error("resync flush left state inconsistent");

	a_single_flush: assert property (@(posedge clk) disable iff (!arst_n)
		sts.again |=> cmd.exec && !sts.again)
		else $error("second pass missing or repeated");

	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		ev_we |-> !full)
		else $error("event written into full queue");

endmodule

// ===== hw/rtl/key_event_queue_with_resync_core.sv =====
// Top level of the keyboard event queue: controller, datapath and channel wiring.
// Depends on kq_pkg, kq_if, kq_ctrl and kq_dp.
//
// Usage:
//  req channel (sink): mode 0 key change (key_id, key_down), 1 focus lost, 2 pop.
//  rsp channel (source): one item per request with status, resync_queued and, for
//  a pop, the oldest event (event_kind, event_key, event_down).
//  One request is in flight at a time. An accepted request passes through the LOAD
//  and EXEC states before the response is valid in OUT, with a second EXEC pass when
//  a pending resync event is queued first: the key state and event RAMs have a
//  registered read, and the single event RAM write port takes the resync event and
//  the item's own event in separate cycles.
//  req.ready is high only while no item is in flight, so a new request can be
//  accepted the cycle after the response is taken.
//  While the receiver holds rsp.ready low the response stays stable and no
//  new request is taken.
//  Reset (arst_n low) empties the queue, releases every key and clears the
//  resync flag; the event RAM needs no clearing since only written slots are read.
//  The queue holds QUEUE_DEPTH-1 events.
module key_event_queue_with_resync_core (
	input logic   clk,
	input logic   arst_n,
	kq_req_if.sink   req,
	kq_rsp_if.source rsp
);
	import kq_pkg::*;

	cmd_t cmd;
	sts_t sts;
	res_t res;

	kq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	kq_dp u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.sts     (sts),
		.in_mode (req.mode),
		.in_key  (req.key_id),
		.in_down (req.key_down),
		.res     (res)
	);

	assign rsp.status        = res.status;
	assign rsp.resync_queued = res.resync_queued;
	assign rsp.event_kind    = res.kind;
	assign rsp.event_key     = res.key;
	assign rsp.event_down    = res.down;

endmodule

// ===== test/kq_event_checker.sv =====
`timescale 1ns / 1ps
// Response checker for key_event_queue_with_resync_core: tracks key state and the
// event ring from accepted requests and compares every response field by field.
// Depends on kq_pkg and the kq_req_if / kq_rsp_if interfaces.
module kq_event_checker (
	input logic clk,
	input logic arst_n,
	kq_req_if   req,
	kq_rsp_if   rsp,
	output int  fail_count,
	output int  outstanding
);
	import kq_pkg::*;

	typedef struct {
		kind_t            kind;
		logic [KEY_W-1:0] key;
		logic             down;
	} slot_t;

	bit    key_pressed [NUM_KEYS];
	slot_t ring [QUEUE_DEPTH];
	int    rd_slot;
	int    wr_slot;
	bit    resync_owed;
	res_t  rsp_due [$];

	initial begin
		fail_count  = 0;
		outstanding = 0;
	end

	function automatic int next_slot(input int p);
		return (p + 1 >= QUEUE_DEPTH) ? 0 : p + 1;
	endfunction

	function automatic bit push_event(input kind_t k, input logic [KEY_W-1:0] key,
		input logic d);
		if (next_slot(wr_slot) == rd_slot)
			return 1'b0;
		ring[wr_slot] = '{kind: k, key: key, down: d};
		wr_slot = next_slot(wr_slot);
		return 1'b1;
	endfunction

	function automatic bit push_release(input kind_t k);
		if (!push_event(k, '0, 1'b0))
			return 1'b0;
		key_pressed = '{default: 1'b0};
		return 1'b1;
	endfunction

	function automatic res_t predict_response(input logic [1:0] m,
		input logic [KEY_W-1:0] k, input logic d);
		res_t r;
		bit   clear_to_go;
		r = '0;
		r.status = ST_IGNORED;
		clear_to_go = 1'b1;
		if (m == MODE_KEY || m == MODE_FOCUS) begin
			// an owed resync goes in ahead of the item's own event
			if (resync_owed) begin
				if (push_release(KIND_RESYNC)) begin
					resync_owed = 1'b0;
					r.resync_queued = 1'b1;
				end else begin
					clear_to_go = 1'b0;
				end
			end
			if (!clear_to_go) begin
				r.status = ST_DROPPED;
			end else if (m == MODE_KEY) begin
				if (k == '0 || key_pressed[k] == d) begin
					r.status = ST_IGNORED;
				end else if (!push_event(KIND_KEY, k, d)) begin
					resync_owed = 1'b1;
					r.status = ST_OVERFLOW;
				end else begin
					key_pressed[k] = d;
					r.status = ST_QUEUED;
				end
			end else if (!push_release(KIND_RELEASE_ALL)) begin
				resync_owed = 1'b1;
				r.status = ST_OVERFLOW;
			end else begin
				r.status = ST_QUEUED;
			end
		end else if (m == MODE_POP) begin
			if (rd_slot == wr_slot) begin
				r.status = ST_EMPTY;
			end else begin
				r.kind = ring[rd_slot].kind;
				r.key  = ring[rd_slot].key;
				r.down = ring[rd_slot].down;
				rd_slot = next_slot(rd_slot);
				r.status = ST_POPPED;
			end
		end
		return r;
	endfunction

	task automatic check_field(input string name, input logic [7:0] want,
		input logic [7:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fail_count++;
		end
	endtask

	always @(posedge clk) begin
		res_t want;
		if (!arst_n) begin
			key_pressed = '{default: 1'b0};
			rd_slot     = 0;
			wr_slot     = 0;
			resync_owed = 1'b0;
			rsp_due.delete();
		end else begin
			if (rsp.valid && rsp.ready) begin
				if (rsp_due.size() == 0) begin
					$error("response item with no request outstanding");
					fail_count++;
				end else begin
					want = rsp_due.pop_front();
					check_field("status", 8'(want.status), 8'(rsp.status));
					check_field("resync_queued", 8'(want.resync_queued), 8'(rsp.resync_queued));
					check_field("event_kind", 8'(want.kind), 8'(rsp.event_kind));
					check_field("event_key", want.key, rsp.event_key);
					check_field("event_down", 8'(want.down), 8'(rsp.event_down));
				end
			end
			if (req.valid && req.ready)
				rsp_due.push_back(predict_response(req.mode, req.key_id, req.key_down));
		end
		outstanding = rsp_due.size();
	end

endmodule

// ===== test/tb_key_event_queue_with_resync_core.sv =====
`timescale 1ns / 1ps
// Testbench top for key_event_queue_with_resync_core: directed and random request
// items with random idling on both channels; kq_event_checker does the checking.
// Depends on kq_pkg, kq_if, the block's RTL and test/kq_event_checker.sv.
module tb_key_event_queue_with_resync_core;
	import kq_pkg::*;

	localparam logic [1:0] MODE_UNUSED   = 2'd3;
	localparam int         ITEM_TARGET   = 800;
	localparam int         IDLE_PCT      = 35;
	localparam int         STALL_LIMIT   = 1000;
	localparam int         SETTLE_CYCLES = 10;

	logic clk;
	logic arst_n;
	int   idle_pct;
	int   item_count;
	int   quiet_cycles;
	int   fail_count;
	int   outstanding;

	kq_req_if req_ch ();
	kq_rsp_if rsp_ch ();

	key_event_queue_with_resync_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	kq_event_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.req         (req_ch),
		.rsp         (rsp_ch),
		.fail_count  (fail_count),
		.outstanding (outstanding)
	);

	initial clk = 1'b0;
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		rsp_ch.ready <= ($urandom_range(99) >= idle_pct);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	task automatic send_item(input logic [1:0] m, input logic [KEY_W-1:0] k, input logic d);
		if ($urandom_range(99) < idle_pct) begin
			req_ch.valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < idle_pct);
		end
		req_ch.valid    <= 1'b1;
		req_ch.mode     <= m;
		req_ch.key_id   <= k;
		req_ch.key_down <= d;
		do @(posedge clk); while (!req_ch.ready);
	endtask

	// mostly a small key set so presses and releases hit the stored state
	function automatic logic [KEY_W-1:0] pick_key();
		int r;
		r = $urandom_range(99);
		if (r < 5)
			return '0;
		if (r < 15)
			return KEY_W'($urandom_range(255));
		return KEY_W'($urandom_range(8, 1));
	endfunction

	task automatic random_item(input int pop_pct);
		int               r;
		logic [1:0]       m;
		logic [KEY_W-1:0] k;
		r = $urandom_range(99);
		k = pick_key();
		if (r < pop_pct)
			m = MODE_POP;
		else if (r < pop_pct + 8)
			m = MODE_FOCUS;
		else if (r < pop_pct + 10)
			m = MODE_UNUSED;
		else
			m = MODE_KEY;
		send_item(m, k, 1'($urandom_range(1)));
		if (m != MODE_UNUSED && !(m == MODE_KEY && k == '0))
			item_count++;
	endtask

	initial begin
		int ep;
		int len;
		int pop_pct;
		arst_n          = 1'b0;
		req_ch.valid    = 1'b0;
		req_ch.mode     = MODE_KEY;
		req_ch.key_id   = '0;
		req_ch.key_down = 1'b0;
		rsp_ch.ready    = 1'b0;
		idle_pct        = IDLE_PCT;
		item_count      = 0;
		quiet_cycles    = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		send_item(MODE_POP, '0, 1'b0);
		send_item(MODE_KEY, '0, 1'b1);
		send_item(MODE_KEY, 8'hff, 1'b1);
		send_item(MODE_KEY, 8'hff, 1'b1);
		send_item(MODE_KEY, 8'hff, 1'b0);
		send_item(MODE_KEY, 8'h80, 1'b0);
		send_item(MODE_KEY, 8'h01, 1'b1);
		send_item(MODE_UNUSED, 8'hff, 1'b1);
		send_item(MODE_FOCUS, '0, 1'b0);
		send_item(MODE_KEY, 8'h01, 1'b0);
		repeat (5) send_item(MODE_POP, 8'hff, 1'b1);

		// flood: overflow, drops, resync; drain: pops with a full hold-off first
		while (item_count < ITEM_TARGET) begin
			idle_pct = (item_count >= 300 && item_count < 420) ? 0 : IDLE_PCT;
			ep = (item_count < 30) ? 1 : $urandom_range(2);
			case (ep)
				0: begin
					pop_pct = 40;
					len = $urandom_range(60, 20);
				end
				1: begin
					pop_pct = 5;
					len = $urandom_range(45, 30);
				end
				default: begin
					pop_pct = 85;
					len = $urandom_range(30, 15);
					req_ch.valid <= 1'b0;
					do @(posedge clk); while (outstanding != 0);
				end
			endcase
			repeat (len) random_item(pop_pct);
		end

		req_ch.valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
